// ===== rtl/cor_pkg.sv =====
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants of the circle octant rasterizer
// Command codes, the column record handed from the step unit to the pixel
// serializer, the pixel record, and the fixed-point factor for the column limit.
// ----------------------------------------------------------------------------
`default_nettype none

package cor_pkg;

    localparam logic CmdStart   = 1'b0;
    localparam logic CmdAdvance = 1'b1;

    // col_limit = floor(radius * 0.70710678), done as radius * LimMul >> LimShift.
    // LimMul is the factor rounded up, and the error stays below the smallest
    // nonzero fraction for any 10-bit radius.
    localparam int unsigned LimShift = 37;
    localparam int unsigned LimMulW  = 37;
    localparam logic [63:0] LimNum   = 64'd70710678 << LimShift;
    localparam logic [63:0] LimMul64 = (LimNum + 64'd99999999) / 64'd100000000;
    localparam logic [LimMulW-1:0] LimMul = LimMul64[LimMulW-1:0];

    // One column as seen by the pixel serializer
    typedef struct packed {
        logic               idle;   // advance while idle: single dummy pixel
        logic [10:0]        col;
        logic signed [10:0] row;
        logic [9:0]         ctr_x;
        logic [9:0]         ctr_y;
        logic [1:0]         color;
        logic               done;
    } t_col;

    typedef struct packed {
        logic signed [11:0] px;
        logic signed [11:0] py;
        logic [1:0]         color;
        logic               inb;
        logic               last;
        logic               done;
    } t_pix;

endpackage

`default_nettype wire

// ===== rtl/cor_column_step.sv =====
// ----------------------------------------------------------------------------
// cor_column_step: circle state and per-column midpoint step
// Holds the center, row, squared terms and step term, and on each loaded
// item forms the column record and updates the state for the next column.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_column_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic        i_cmd,
    input  wire logic [9:0]  i_ctr_x,
    input  wire logic [9:0]  i_ctr_y,
    input  wire logic [9:0]  i_radius,
    input  wire logic [1:0]  i_color,
    output cor_pkg::t_col    o_col
);

    logic [9:0]         r_ctr_x, n_ctr_x;
    logic [9:0]         r_ctr_y, n_ctr_y;
    logic [10:0]        r_col, n_col;
    logic signed [10:0] r_row, n_row;
    logic [20:0]        r_sq_cur, n_sq_cur;
    logic signed [21:0] r_sq_track, n_sq_track;
    logic signed [11:0] r_step, n_step;
    logic [9:0]         r_col_limit, n_col_limit;
    logic [1:0]         r_color, n_color;
    logic               r_active, n_active;

    logic signed [22:0] w_diff;
    logic signed [22:0] w_step_x;
    logic signed [22:0] w_sq_sub;
    logic               w_drop;
    logic               w_done;
    logic signed [10:0] w_row_adv;
    logic               w_r0;
    logic signed [10:0] w_row_st;
    logic [19:0]        w_sq_st;
    logic [46:0]        w_lim_prod;
    logic               w_start;

    assign w_start  = (i_cmd == cor_pkg::CmdStart);

    // Advance: row drops when sq_cur - sq_track >= step_term
    assign w_diff    = $signed({2'b00, r_sq_cur}) - $signed({r_sq_track[21], r_sq_track});
    assign w_step_x  = $signed({{11{r_step[11]}}, r_step});
    assign w_drop    = (w_diff >= w_step_x);
    assign w_sq_sub  = $signed({2'b00, r_sq_cur}) - w_step_x;
    assign w_row_adv = w_drop ? (r_row - 11'sd1) : r_row;
    assign w_done    = (r_col == ({1'b0, r_col_limit} + 11'd1));

    // Start: both squared terms equal, so the row drops only for a zero radius
    assign w_r0       = (i_radius == 10'd0);
    assign w_row_st   = w_r0 ? -11'sd1 : $signed({1'b0, i_radius});
    assign w_sq_st    = {10'd0, i_radius} * {10'd0, i_radius};
    assign w_lim_prod = {37'd0, i_radius} * {10'd0, cor_pkg::LimMul};

    always_comb begin
        n_ctr_x     = r_ctr_x;
        n_ctr_y     = r_ctr_y;
        n_col       = r_col;
        n_row       = r_row;
        n_sq_cur    = r_sq_cur;
        n_sq_track  = r_sq_track;
        n_step      = r_step;
        n_col_limit = r_col_limit;
        n_color     = r_color;
        n_active    = r_active;
        if (i_load) begin
            if (w_start) begin
                n_ctr_x     = i_ctr_x;
                n_ctr_y     = i_ctr_y;
                n_color     = i_color;
                n_col       = 11'd1;
                n_row       = w_row_st;
                n_sq_cur    = {1'b0, w_sq_st} + {20'd0, w_r0};
                n_sq_track  = $signed({2'b00, w_sq_st}) + 22'sd3;
                n_step      = w_r0 ? -12'sd3 : ($signed({1'b0, i_radius, 1'b0}) - 12'sd1);
                n_col_limit = w_lim_prod[46:37];
                n_active    = 1'b1;
            end else if (r_active) begin
                n_col      = r_col + 11'd1;
                n_row      = w_row_adv;
                if (w_drop) begin
                    n_sq_cur = w_sq_sub[20:0];
                    n_step   = r_step - 12'sd2;
                end
                n_sq_track = r_sq_track + 22'sd3 - $signed({10'd0, r_col, 1'b0});
                n_active   = !w_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr_x     <= '0;
            r_ctr_y     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_sq_cur    <= '0;
            r_sq_track  <= '0;
            r_step      <= '0;
            r_col_limit <= '0;
            r_color     <= '0;
            r_active    <= 1'b0;
        end else begin
            r_ctr_x     <= n_ctr_x;
            r_ctr_y     <= n_ctr_y;
            r_col       <= n_col;
            r_row       <= n_row;
            r_sq_cur    <= n_sq_cur;
            r_sq_track  <= n_sq_track;
            r_step      <= n_step;
            r_col_limit <= n_col_limit;
            r_color     <= n_color;
            r_active    <= n_active;
        end
    end

    always_comb begin
        o_col.idle  = !w_start && !r_active;
        o_col.col   = w_start ? 11'd0 : r_col;
        o_col.row   = w_start ? w_row_st : w_row_adv;
        o_col.ctr_x = w_start ? i_ctr_x : r_ctr_x;
        o_col.ctr_y = w_start ? i_ctr_y : r_ctr_y;
        o_col.color = w_start ? i_color : r_color;
        o_col.done  = w_start ? 1'b0 : w_done;
    end

endmodule

`default_nettype wire

// ===== rtl/cor_pixel_emit.sv =====
// ----------------------------------------------------------------------------
// cor_pixel_emit: column register and eight-way mirror serializer
// Holds one column record and sends its mirrored pixels one per transfer,
// with the canvas clip flag and the run and circle end marks.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_pixel_emit #(
    parameter int CANVAS_SIZE = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire cor_pkg::t_col i_col,
    output logic               o_free,
    output logic               o_valid,
    input  wire logic          i_ready,
    output cor_pkg::t_pix      o_pix
);

    localparam logic signed [13:0] CanvasLim = 14'(CANVAS_SIZE);

    logic          r_vld;
    logic [2:0]    r_idx;
    cor_pkg::t_col r_col;

    logic               w_last;
    logic               w_xfer;
    logic signed [11:0] w_u;
    logic signed [11:0] w_v;
    logic signed [11:0] w_first;
    logic signed [11:0] w_second;
    logic signed [13:0] w_fx;
    logic signed [13:0] w_fy;
    logic signed [13:0] w_px;
    logic signed [13:0] w_py;
    logic               w_inb;

    assign w_last  = r_col.idle || (r_idx == 3'd7);
    assign w_xfer  = r_vld && i_ready;
    assign o_free  = !r_vld || (w_xfer && w_last);
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (w_xfer) begin
            if (w_last) begin
                r_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_col <= i_col;
        end
    end

    // Mirror: bit 2 swaps the axes, bits 1 and 0 negate the x and y terms after the swap
    assign w_u      = $signed({1'b0, r_col.col});
    assign w_v      = $signed({r_col.row[10], r_col.row});
    assign w_first  = r_idx[2] ? w_v : w_u;
    assign w_second = r_idx[2] ? w_u : w_v;
    assign w_fx     = $signed({{2{w_first[11]}}, w_first});
    assign w_fy     = $signed({{2{w_second[11]}}, w_second});
    assign w_px     = (r_idx[1] ? -w_fx : w_fx) + $signed({4'd0, r_col.ctr_x});
    assign w_py     = (r_idx[0] ? -w_fy : w_fy) + $signed({4'd0, r_col.ctr_y});
    assign w_inb    = (w_px >= 14'sd0) && (w_px < CanvasLim)
                   && (w_py >= 14'sd0) && (w_py < CanvasLim);

    always_comb begin
        o_pix.color = r_col.color;
        o_pix.last  = w_last;
        if (r_col.idle) begin
            o_pix.px   = '0;
            o_pix.py   = '0;
            o_pix.inb  = 1'b0;
            o_pix.done = 1'b1;
        end else begin
            o_pix.px   = w_px[11:0];
            o_pix.py   = w_py[11:0];
            o_pix.inb  = w_inb;
            o_pix.done = r_col.done && (r_idx == 3'd7);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/circle_octant_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_unit: incremental midpoint circle rasterizer
// Start items load a circle, advance items step one column; every column
// comes out as eight mirrored pixel transfers.
// ----------------------------------------------------------------------------
// A start item (tuser = 0) loads center, radius and color and emits column 0;
// each advance item (tuser = 1) emits the next column. Every column leaves as
// eight pixel transfers, one per cycle while tready holds, in the order (x,y) (x,-y)
// (-x,y) (-x,-y) (y,x) (y,-x) (-y,x) (-y,-x) around the center, with tlast on the
// eighth; the eighth pixel of the final column also raises circle_done. An
// advance with no circle in progress yields one pixel at (0,0) with in_bounds
// clear and tlast and circle_done set. The pace is set by the single-pixel
// output serializer; the next item is taken into the input register and
// stepped into the column register while the previous column drains, so a
// column follows the last pixel of the one before with no gap.
`default_nettype none

module circle_octant_rasterizer_unit #(
    parameter int CANVAS_SIZE = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // center_x[9:0] center_y[19:10] radius[29:20] color[31:30]
    input  wire logic [0:0]  i_s_tuser,   // cmd[0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // pixel_x[11:0] pixel_y[23:12] pixel_color[25:24] zero[31:26]
    output logic [1:0]       o_m_tuser,   // in_bounds[0] circle_done[1]
    output logic             o_m_tlast    // last_of_run
);

    logic          r_in_vld;
    logic          r_in_cmd;
    logic [31:0]   r_in_data;

    logic          w_free;
    logic          w_take;
    cor_pkg::t_col w_col;
    cor_pkg::t_pix w_pix;

    assign w_take     = r_in_vld && w_free;
    assign o_s_tready = !r_in_vld || w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    // hold the payload until the step unit takes it
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd  <= i_s_tuser[0];
            r_in_data <= i_s_tdata;
        end
    end

    cor_column_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take),
        .i_cmd    (r_in_cmd),
        .i_ctr_x  (r_in_data[9:0]),
        .i_ctr_y  (r_in_data[19:10]),
        .i_radius (r_in_data[29:20]),
        .i_color  (r_in_data[31:30]),
        .o_col    (w_col)
    );

    cor_pixel_emit #(
        .CANVAS_SIZE (CANVAS_SIZE)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take),
        .i_col   (w_col),
        .o_free  (w_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_pix   (w_pix)
    );

    assign o_m_tdata = {6'd0, w_pix.color, w_pix.py, w_pix.px};
    assign o_m_tuser = {w_pix.done, w_pix.inb};
    assign o_m_tlast = w_pix.last;

endmodule

`default_nettype wire

// ===== rtl/cor_checker.sv =====
// ----------------------------------------------------------------------------
// cor_checker: port-level checks of the circle octant rasterizer
// Watches the pixel stream of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,
    input  wire logic [1:0]  i_m_tuser,
    input  wire logic        i_m_tlast
);

    // a stalled pixel transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("stalled pixel transfer changed");

    // circle end only on the last pixel of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1] |-> i_m_tlast)
        else $error("circle_done without last_of_run");

    // an in-bounds pixel never has a negative coordinate
    a_inb_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |-> !i_m_tdata[11] && !i_m_tdata[23])
        else $error("in_bounds pixel with negative coordinate");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("pixel valid after reset");

endmodule

bind circle_octant_rasterizer_unit cor_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire

// ===== bench/circle_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// circle_pixel_checker: pixel stream checker for the circle octant rasterizer
// Watches both stream channels, keeps its own copy of the rasterizer state,
// predicts the eight mirrored pixels of every accepted column (or the single
// dummy pixel of an advance with no circle in progress) and compares each
// accepted pixel transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module circle_pixel_checker #(
    parameter int CANVAS_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // center_x[9:0] center_y[19:10] radius[29:20] color[31:30]
    input  logic [0:0]  i_s_tuser,   // cmd[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // pixel_x[11:0] pixel_y[23:12] pixel_color[25:24]
    input  logic [1:0]  i_m_tuser,   // in_bounds[0] circle_done[1]
    input  logic        i_m_tlast,   // last_of_run
    output int          o_errors,
    output int          o_pending
);

    // Shadow rasterizer state
    logic [9:0]  ctr_x;
    logic [9:0]  ctr_y;
    logic [9:0]  col_limit;
    logic [10:0] col;
    logic [1:0]  draw_color;
    logic        active;
    int          row;
    int          step_term;
    longint      sq_cur;
    longint      sq_track;

    cor_pkg::t_pix pixel_q[$];
    int            errors = 0;

    function automatic void push_pixel(int px, int py, logic inb_ok, logic last, logic done);
        cor_pkg::t_pix p;
        p.px    = 12'(px);
        p.py    = 12'(py);
        p.color = draw_color;
        p.inb   = inb_ok && px >= 0 && px < CANVAS_SIZE && py >= 0 && py < CANVAS_SIZE;
        p.last  = last;
        p.done  = done;
        pixel_q.insert(pixel_q.size(), p);
    endfunction

    function automatic void emit_column();
        int   x;
        int   y;
        int   a;
        int   b;
        logic done;
        x = int'(col);
        a = int'(ctr_x);
        b = int'(ctr_y);
        // drop the row when the squared difference reaches the step term
        if (sq_cur - sq_track >= longint'(step_term)) begin
            sq_cur    -= longint'(step_term);
            row       -= 1;
            step_term -= 2;
        end
        y    = row;
        done = (x == int'(col_limit) + 1);
        push_pixel( x + a,  y + b, 1'b1, 1'b0, 1'b0);
        push_pixel( x + a, -y + b, 1'b1, 1'b0, 1'b0);
        push_pixel(-x + a,  y + b, 1'b1, 1'b0, 1'b0);
        push_pixel(-x + a, -y + b, 1'b1, 1'b0, 1'b0);
        push_pixel( y + a,  x + b, 1'b1, 1'b0, 1'b0);
        push_pixel( y + a, -x + b, 1'b1, 1'b0, 1'b0);
        push_pixel(-y + a,  x + b, 1'b1, 1'b0, 1'b0);
        push_pixel(-y + a, -x + b, 1'b1, 1'b1, done);
        sq_track -= longint'(2 * x - 3);
        col      += 11'd1;
        if (done) begin
            active = 1'b0;
        end
    endfunction

    function automatic void rasterize_item(logic cmd, logic [9:0] cx, logic [9:0] cy,
                                           logic [9:0] rad, logic [1:0] clr);
        if (cmd == cor_pkg::CmdStart) begin
            ctr_x      = cx;
            ctr_y      = cy;
            draw_color = clr;
            col        = '0;
            row        = int'(rad);
            sq_cur     = longint'(rad) * longint'(rad);
            sq_track   = sq_cur;
            step_term  = 2 * int'(rad) - 1;
            col_limit  = 10'((longint'(rad) * 70710678) / 100000000);
            active     = 1'b1;
            emit_column();
        end else if (!active) begin
            // advance with no circle: one pixel at (0,0), not in bounds, ending the run
            push_pixel(0, 0, 1'b0, 1'b1, 1'b1);
        end else begin
            emit_column();
        end
    endfunction

    always @(posedge i_clk) begin : watch
        cor_pkg::t_pix got;
        cor_pkg::t_pix want;
        if (!i_rst_n) begin
            ctr_x      = '0;
            ctr_y      = '0;
            col_limit  = '0;
            col        = '0;
            draw_color = '0;
            active     = 1'b0;
            row        = 0;
            step_term  = 0;
            sq_cur     = 0;
            sq_track   = 0;
            pixel_q.delete();
        end else begin
            // check the output transfer first: it never stems from this edge's input
            if (i_m_tvalid && i_m_tready) begin
                got.px    = i_m_tdata[11:0];
                got.py    = i_m_tdata[23:12];
                got.color = i_m_tdata[25:24];
                got.inb   = i_m_tuser[0];
                got.done  = i_m_tuser[1];
                got.last  = i_m_tlast;
                if (pixel_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected pixel: x=%0d y=%0d color=%0d inb=%0b last=%0b done=%0b",
                                 got.px, got.py, got.color, got.inb, got.last, got.done);
                    end
                end else begin
                    want = pixel_q.pop_front();
                    if (got.px !== want.px || got.py !== want.py || got.color !== want.color ||
                        got.inb !== want.inb || got.last !== want.last ||
                        got.done !== want.done) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("pixel mismatch: expected x=%0d y=%0d color=%0d inb=%0b last=%0b done=%0b",
                                     want.px, want.py, want.color, want.inb, want.last, want.done);
                            $display("                actual   x=%0d y=%0d color=%0d inb=%0b last=%0b done=%0b",
                                     got.px, got.py, got.color, got.inb, got.last, got.done);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                rasterize_item(i_s_tuser[0], i_s_tdata[9:0], i_s_tdata[19:10],
                               i_s_tdata[29:20], i_s_tdata[31:30]);
            end
        end
        o_errors  <= errors;
        o_pending <= pixel_q.size();
    end

endmodule

// ===== bench/tb_circle_octant_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_circle_octant_rasterizer_unit: testbench of the circle octant rasterizer
// Drives start and advance items with random gaps and output stalls, a long
// output hold-off and a drain pause; a checker beside the block predicts and
// compares every pixel transfer. Directed circles cover the field extremes,
// zero radius, advance with no circle and restart mid-circle; random circles
// follow, mostly complete small ones, some dropped large ones and some noise.
// ----------------------------------------------------------------------------
module tb_circle_octant_rasterizer_unit;

    localparam int CANVAS_SIZE  = 1024;
    localparam int ITEM_TARGET  = 420;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 24;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // center_x[9:0] center_y[19:10] radius[29:20] color[31:30]
    logic [0:0]  s_tuser;    // cmd[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // pixel_x[11:0] pixel_y[23:12] pixel_color[25:24]
    logic [1:0]  m_tuser;    // in_bounds[0] circle_done[1]
    logic        m_tlast;    // last_of_run

    int errors;
    int pending;
    int items_sent = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    circle_octant_rasterizer_unit #(
        .CANVAS_SIZE(CANVAS_SIZE)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    circle_pixel_checker #(
        .CANVAS_SIZE(CANVAS_SIZE)
    ) i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Pixel receiver: random stalls, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end else if (rx_idle_on) begin
                m_tready <= ($urandom_range(99) >= 14);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // End the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_circle_octant_rasterizer_unit NOT OK");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [9:0] cx, input logic [9:0] cy,
                             input logic [9:0] rad, input logic [1:0] clr);
        while (tx_idle_on && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {clr, rad, cy, cx};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (items_sent == 100) begin
            hold_req = 1'b1;
        end
        tx_idle_on = !(items_sent >= 150 && items_sent < 230);
        rx_idle_on = tx_idle_on;
        // pause the sender until every pixel is out
        if (items_sent == 260) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
            @(posedge clk);
        end
    endtask

    task automatic run_circle(input logic [9:0] cx, input logic [9:0] cy, input logic [9:0] rad,
                              input logic [1:0] clr, input int n_adv);
        send_item(cor_pkg::CmdStart, cx, cy, rad, clr);
        repeat (n_adv) begin
            send_item(cor_pkg::CmdAdvance, 10'($urandom_range(1023)),
                      10'($urandom_range(1023)), 10'($urandom_range(1023)),
                      2'($urandom_range(3)));
        end
    endtask

    initial begin : stimulus
        int         shape;
        int         lim;
        int         n_adv;
        logic [9:0] rad;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = cor_pkg::CmdStart;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // advance with no circle right after reset
        send_item(cor_pkg::CmdAdvance, 10'd1023, 10'd1023, 10'd1023, 2'd3);
        // zero radius, both columns, then one advance past the end
        run_circle(10'd0, 10'd0, 10'd0, 2'd0, 2);
        // largest radius in the far corner, dropped by a restart
        run_circle(10'd1023, 10'd1023, 10'd1023, 2'd3, 3);
        run_circle(10'd1023, 10'd0, 10'd5, 2'd2, 4);
        run_circle(10'd0, 10'd1023, 10'd1, 2'd1, 2);
        run_circle(10'd300, 10'd700, 10'd10, 2'd2, 8);

        while (items_sent < ITEM_TARGET) begin
            shape = $urandom_range(99);
            if (shape < 88) begin
                if (shape < 50) begin
                    rad = 10'($urandom_range(15));
                end else if (shape < 75) begin
                    rad = 10'($urandom_range(80, 16));
                end else begin
                    rad = 10'($urandom_range(1023));
                end
                lim = int'((longint'(rad) * 70710678) / 100000000);
                if (shape < 75) begin
                    n_adv = lim + 1 + (($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0);
                end else begin
                    // large circle: a few columns, then drop it
                    n_adv = $urandom_range((lim < 6) ? lim : 6);
                end
                run_circle(10'($urandom_range(1023)), 10'($urandom_range(1023)), rad,
                           2'($urandom_range(3)), n_adv);
            end else begin
                send_item(1'($urandom_range(1)), 10'($urandom_range(1023)),
                          10'($urandom_range(1023)), 10'($urandom_range(1023)),
                          2'($urandom_range(3)));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_circle_octant_rasterizer_unit OK");
        end else begin
            $display("tb_circle_octant_rasterizer_unit NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cor_pkg.sv
rtl/cor_column_step.sv
rtl/cor_pixel_emit.sv
rtl/circle_octant_rasterizer_unit.sv
rtl/cor_checker.sv
bench/circle_pixel_checker.sv
bench/tb_circle_octant_rasterizer_unit.sv
